>>> src/xtpm_pkg.sv
`timescale 1ns / 1ps
// Package for the tag pair matcher: state codes, status codes, tag kinds
// and default sizes. It has no dependencies.
package xtpm_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_NAME_BITS   = 32;
    localparam int DEF_OFFSET_BITS = 31;

    localparam logic [1:0] KIND_OPEN  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;

    typedef enum logic [2:0] {
        STAT_PUSHED   = 3'd0,
        STAT_MATCHED  = 3'd1,
        STAT_ORPHAN   = 3'd2,
        STAT_SELF     = 3'd3,
        STAT_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SHIFT
    } t_state;

endpackage

>>> src/xtpm_stack_mem.sv
`timescale 1ns / 1ps
// Stack storage for the tag pair matcher: one write port and one read port
// with registered read data. It has no dependencies.
module xtpm_stack_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 63,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/xtpm_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the tag pair matcher: push, top-down search, shift-down removal
// and the result register. It depends on xtpm_pkg and drives xtpm_stack_mem.
module xtpm_ctrl
    import xtpm_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int NAME_BITS   = DEF_NAME_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int AW          = $clog2(STACK_DEPTH),
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1),
    parameter int WIDTH       = NAME_BITS + OFFSET_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_new_document,
    input  logic [1:0]             i_tag_kind,
    input  logic [NAME_BITS-1:0]   i_name_id,
    input  logic [OFFSET_BITS-1:0] i_start_offset,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_status,
    output logic [OFFSET_BITS-1:0] o_open_offset,
    output logic [OFFSET_BITS-1:0] o_close_offset,
    output logic [NAME_BITS-1:0]   o_pair_name,
    output logic [CNT_W-1:0]       o_open_count,
    output logic                   o_mem_we,
    output logic [AW-1:0]          o_mem_waddr,
    output logic [WIDTH-1:0]       o_mem_wdata,
    output logic [AW-1:0]          o_mem_raddr,
    input  logic [WIDTH-1:0]       i_mem_rdata
);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [AW-1:0]          r_ptr, n_ptr;
    logic [NAME_BITS-1:0]   r_name, n_name;
    logic [OFFSET_BITS-1:0] r_close_off, n_close_off;
    logic [OFFSET_BITS-1:0] r_open_off, n_open_off;
    logic                   r_out_valid, n_out_valid;
    t_status                r_status, n_status;
    logic [OFFSET_BITS-1:0] r_out_open, n_out_open;
    logic [OFFSET_BITS-1:0] r_out_close, n_out_close;
    logic [NAME_BITS-1:0]   r_out_name, n_out_name;
    logic [CNT_W-1:0]       r_out_count, n_out_count;

    logic                   in_ready;
    logic [CNT_W-1:0]       eff_cnt;
    logic [NAME_BITS-1:0]   rd_name;
    logic [OFFSET_BITS-1:0] rd_off;

    assign rd_name  = i_mem_rdata[WIDTH-1:OFFSET_BITS];
    assign rd_off   = i_mem_rdata[OFFSET_BITS-1:0];
    assign in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign eff_cnt  = i_new_document ? '0 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_name      <= n_name;
        r_close_off <= n_close_off;
        r_open_off  <= n_open_off;
        r_status    <= n_status;
        r_out_open  <= n_out_open;
        r_out_close <= n_out_close;
        r_out_name  <= n_out_name;
        r_out_count <= n_out_count;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_name      = r_name;
        n_close_off = r_close_off;
        n_open_off  = r_open_off;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_out_open  = r_out_open;
        n_out_close = r_out_close;
        n_out_name  = r_out_name;
        n_out_count = r_out_count;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_ptr;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_ptr;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && in_ready) begin
                    n_cnt       = eff_cnt;
                    n_out_open  = '0;
                    n_out_close = '0;
                    n_out_name  = '0;
                    n_out_count = eff_cnt;
                    case (i_tag_kind)
                        KIND_OPEN: begin
                            n_out_valid = 1'b1;
                            if (eff_cnt == CNT_W'(STACK_DEPTH)) begin
                                n_status = STAT_OVERFLOW;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(eff_cnt);
                                o_mem_wdata = {i_name_id, i_start_offset};
                                n_cnt       = eff_cnt + CNT_W'(1);
                                n_out_count = eff_cnt + CNT_W'(1);
                                n_status    = STAT_PUSHED;
                            end
                        end
                        KIND_CLOSE: begin
                            if (eff_cnt == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = STAT_ORPHAN;
                            end else begin
                                n_ptr       = AW'(eff_cnt - CNT_W'(1));
                                o_mem_raddr = AW'(eff_cnt - CNT_W'(1));
                                n_name      = i_name_id;
                                n_close_off = i_start_offset;
                                n_state     = ST_CMP;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_status    = STAT_SELF;
                        end
                    endcase
                end
            end
            ST_CMP: begin
                if (rd_name == r_name) begin
                    n_open_off = rd_off;
                    if (CNT_W'(r_ptr) + CNT_W'(1) == r_cnt) begin
                        n_cnt       = r_cnt - CNT_W'(1);
                        n_out_valid = 1'b1;
                        n_status    = STAT_MATCHED;
                        n_out_open  = rd_off;
                        n_out_close = r_close_off;
                        n_out_name  = r_name;
                        n_out_count = r_cnt - CNT_W'(1);
                        n_state     = ST_IDLE;
                    end else begin
                        o_mem_raddr = r_ptr + AW'(1);
                        n_state     = ST_SHIFT;
                    end
                end else if (r_ptr == '0) begin
                    n_out_valid = 1'b1;
                    n_status    = STAT_ORPHAN;
                    n_out_open  = '0;
                    n_out_close = '0;
                    n_out_name  = '0;
                    n_out_count = r_cnt;
                    n_state     = ST_IDLE;
                end else begin
                    n_ptr       = r_ptr - AW'(1);
                    o_mem_raddr = r_ptr - AW'(1);
                end
            end
            ST_SHIFT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr;
                o_mem_wdata = i_mem_rdata;
                if (CNT_W'(r_ptr) + CNT_W'(2) == r_cnt) begin
                    n_cnt       = r_cnt - CNT_W'(1);
                    n_out_valid = 1'b1;
                    n_status    = STAT_MATCHED;
                    n_out_open  = r_open_off;
                    n_out_close = r_close_off;
                    n_out_name  = r_name;
                    n_out_count = r_cnt - CNT_W'(1);
                    n_state     = ST_IDLE;
                end else begin
                    n_ptr       = r_ptr + AW'(1);
                    o_mem_raddr = r_ptr + AW'(2);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready     = in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_open_offset  = r_out_open;
    assign o_close_offset = r_out_close;
    assign o_pair_name    = r_out_name;
    assign o_open_count   = r_out_count;

endmodule

>>> src/xml_tag_pair_matcher_top.sv
`timescale 1ns / 1ps
// Channel  Handshake                  Payload
// input    i_in_valid / o_in_ready    new_document, tag_kind, name_id, start_offset
// output   o_out_valid / i_out_ready  status, open/close offsets, pair_name, open_count
//
// Open, self-closing and overflow tags, and close tags on an empty stack, are answered from the idle state.
// A close tag searches S entries from the top, then shifts M entries
// down after a match, one memory access a cycle through the single stack read port.
// One transaction is in flight at a time; the result register is drained by i_out_ready.
// Reset clears the held count, the state and the result valid; the stack memory needs no clearing.
// Top level of the tag pair matcher. It depends on xtpm_pkg, xtpm_ctrl and xtpm_stack_mem.
module xml_tag_pair_matcher_top
    import xtpm_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int NAME_BITS   = DEF_NAME_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_new_document,
    input  logic [1:0]             i_tag_kind,
    input  logic [NAME_BITS-1:0]   i_name_id,
    input  logic [OFFSET_BITS-1:0] i_start_offset,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_status,
    output logic [OFFSET_BITS-1:0] o_open_offset,
    output logic [OFFSET_BITS-1:0] o_close_offset,
    output logic [NAME_BITS-1:0]   o_pair_name,
    output logic [CNT_W-1:0]       o_open_count
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int WIDTH = NAME_BITS + OFFSET_BITS;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [WIDTH-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [WIDTH-1:0] mem_rdata;

    xtpm_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .NAME_BITS   (NAME_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .AW          (AW),
        .CNT_W       (CNT_W),
        .WIDTH       (WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_new_document (i_new_document),
        .i_tag_kind     (i_tag_kind),
        .i_name_id      (i_name_id),
        .i_start_offset (i_start_offset),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_open_offset  (o_open_offset),
        .o_close_offset (o_close_offset),
        .o_pair_name    (o_pair_name),
        .o_open_count   (o_open_count),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    xtpm_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

>>> src/xtpm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the tag pair matcher and the bind that attaches them
// to the top level. It depends on xtpm_pkg.
module xtpm_checker
    import xtpm_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int NAME_BITS   = DEF_NAME_BITS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [2:0]             o_status,
    input logic [OFFSET_BITS-1:0] o_open_offset,
    input logic [OFFSET_BITS-1:0] o_close_offset,
    input logic [NAME_BITS-1:0]   o_pair_name,
    input logic [CNT_W-1:0]       o_open_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_open_count))
        else $error("Result transaction changed while stalled.");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("Input accepted while the result register is blocked.");

    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != STAT_MATCHED) |->
            (o_open_offset == '0) && (o_close_offset == '0) && (o_pair_name == '0))
        else $error("Pair fields are not zero on an unmatched result.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_open_count <= CNT_W'(STACK_DEPTH))
        else $error("Open count exceeds the stack depth.");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_OVERFLOW) |->
            o_open_count == CNT_W'(STACK_DEPTH))
        else $error("Overflow reported while the stack is not full.");

endmodule

bind xml_tag_pair_matcher_top xtpm_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .NAME_BITS   (NAME_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .CNT_W       (CNT_W)
) u_xtpm_checker (.*);
